// ----- rtl/rsd_pkg.sv -----
// shared constants and types for the rotating server dispatcher
package rsd_pkg;

   localparam int MAX_SERVERS_DEF = 16;
   localparam int NUM_SERVERS_RST = 16;

   localparam int NUM_W    = 5;
   localparam int ARRIVE_W = 30;
   localparam int LOAD_W   = 30;
   localparam int TIME_W   = 31;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SERVER_W = 4;
   localparam int OPCODE_W = 1;

   localparam int REQ_DATA_W = ((ARRIVE_W + LOAD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SERVER_W + COUNT_W + 7) / 8) * 8;

   localparam logic [OPCODE_W-1:0] OP_DISPATCH = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_REPORT   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ASSIGNED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BUSIEST  = 2'd2;

   typedef struct packed {
      logic capture;
      logic compare;
      logic dispatch;
      logic scan_max;
      logic scan_emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_last;
      logic scan_match;
   } sts_type;

endpackage

// ----- rtl/rsd_ctrl.sv -----
// controller state machine for request dispatch and busiest-server reports
module rsd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_op,
   input  rsd_pkg::sts_type sts,
   output rsd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_PICK,
      S_SCAN,
      S_SEND
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = (req_op == rsd_pkg::OP_DISPATCH) ? S_CMP : S_SCAN;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in = S_PICK;
         end
         S_PICK: begin
            if (sts.out_free) begin
               cmd.dispatch = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_max = 1'b1;
            if (sts.scan_last) begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (!sts.scan_match || sts.out_free) begin
               cmd.scan_emit = 1'b1;
               if (sts.scan_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/rsd_datapath.sv -----
// server tables, rotating pick, report scan and result register
module rsd_datapath #(
   parameter int MAX_SERVERS = rsd_pkg::MAX_SERVERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rsd_pkg::NUM_W-1:0]         csr_wr_data,
   input  logic [rsd_pkg::ARRIVE_W-1:0]      req_arrive,
   input  logic [rsd_pkg::LOAD_W-1:0]        req_load,
   input  rsd_pkg::cmd_type                  cmd,
   output rsd_pkg::sts_type                  sts,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rsd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [rsd_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);
   localparam int K_RST = (rsd_pkg::NUM_SERVERS_RST > MAX_SERVERS) ?
                          MAX_SERVERS : rsd_pkg::NUM_SERVERS_RST;

   logic [rsd_pkg::TIME_W-1:0]   free_at_ff [MAX_SERVERS];
   logic [rsd_pkg::COUNT_W-1:0]  count_ff   [MAX_SERVERS];
   logic [MAX_SERVERS-1:0]       free_ff;
   logic [IDX_W-1:0]             pos_ff;
   logic [CNT_W-1:0]             k_ff;
   logic [rsd_pkg::ARRIVE_W-1:0] arrive_ff;
   logic [rsd_pkg::LOAD_W-1:0]   load_ff;
   logic [IDX_W-1:0]             scan_ff;
   logic [rsd_pkg::COUNT_W-1:0]  top_ff;
   logic [IDX_W-1:0]             lastidx_ff;

   logic                         out_valid_ff;
   logic [rsd_pkg::STATUS_W-1:0] out_status_ff;
   logic [rsd_pkg::SERVER_W-1:0] out_server_ff;
   logic [rsd_pkg::COUNT_W-1:0]  out_count_ff;
   logic                         out_last_ff;

   logic [MAX_SERVERS-1:0]       avail;
   logic [MAX_SERVERS-1:0]       ahead;
   logic [MAX_SERVERS-1:0]       cand;
   logic [MAX_SERVERS-1:0]       onehot;
   logic [IDX_W-1:0]             pick;
   logic                         found;
   logic [IDX_W-1:0]             rd_idx;
   logic [rsd_pkg::COUNT_W-1:0]  cnt_rd;
   logic [rsd_pkg::COUNT_W-1:0]  cnt_next;
   logic [rsd_pkg::TIME_W-1:0]   done_at;
   logic [CNT_W-1:0]             pos_inc;
   logic [CNT_W-1:0]             scan_inc;
   logic [CNT_W-1:0]             k_in;
   logic                         out_load;

   // rotating pick: prefer free servers at or after the position, else lowest
   always_comb begin
      pick = '0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
         avail[i] = free_ff[i] && (CNT_W'(i) < k_ff);
         ahead[i] = avail[i] && (IDX_W'(i) >= pos_ff);
      end
      cand   = (|ahead) ? ahead : avail;
      onehot = cand & (~cand + MAX_SERVERS'(1));
      found  = |avail;
      for (int i = 0; i < MAX_SERVERS; i++) begin
         if (onehot[i]) begin
            pick = pick | IDX_W'(i);
         end
      end
   end

   assign rd_idx   = cmd.dispatch ? pick : scan_ff;
   assign cnt_rd   = count_ff[rd_idx];
   assign cnt_next = (cnt_rd == '1) ? cnt_rd : cnt_rd + rsd_pkg::COUNT_W'(1);
   assign done_at  = rsd_pkg::TIME_W'(arrive_ff) + rsd_pkg::TIME_W'(load_ff);
   assign pos_inc  = CNT_W'(pos_ff) + CNT_W'(1);
   assign scan_inc = CNT_W'(scan_ff) + CNT_W'(1);

   always_comb begin
      if (csr_wr_data == '0) begin
         k_in = CNT_W'(1);
      end else if (int'(csr_wr_data) > MAX_SERVERS) begin
         k_in = CNT_W'(MAX_SERVERS);
      end else begin
         k_in = CNT_W'(csr_wr_data);
      end
   end

   assign sts.out_free   = !out_valid_ff || rsp_tready;
   assign sts.scan_last  = (scan_inc >= k_ff);
   assign sts.scan_match = (cnt_rd == top_ff);

   assign out_load = cmd.dispatch || (cmd.scan_emit && sts.scan_match);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            free_at_ff[i] <= '0;
            count_ff[i]   <= '0;
         end
         pos_ff       <= '0;
         k_ff         <= CNT_W'(K_RST);
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            k_ff <= k_in;
         end
         if (cmd.dispatch) begin
            pos_ff <= (pos_inc >= k_ff) ? '0 : IDX_W'(pos_inc);
            if (found) begin
               free_at_ff[pick] <= done_at;
               count_ff[pick]   <= cnt_next;
            end
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         arrive_ff  <= req_arrive;
         load_ff    <= req_load;
         scan_ff    <= '0;
         top_ff     <= '0;
         lastidx_ff <= '0;
      end
      if (cmd.compare) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            free_ff[i] <= (free_at_ff[i] <= rsd_pkg::TIME_W'(arrive_ff));
         end
      end
      if (cmd.scan_max) begin
         if (cnt_rd > top_ff) begin
            top_ff     <= cnt_rd;
            lastidx_ff <= scan_ff;
         end else if (cnt_rd == top_ff) begin
            lastidx_ff <= scan_ff;
         end
         scan_ff <= sts.scan_last ? '0 : IDX_W'(scan_inc);
      end
      if (cmd.scan_emit) begin
         scan_ff <= IDX_W'(scan_inc);
      end
      if (cmd.dispatch) begin
         out_status_ff <= found ? rsd_pkg::STATUS_ASSIGNED : rsd_pkg::STATUS_DROPPED;
         out_server_ff <= found ? rsd_pkg::SERVER_W'(pick) : '0;
         out_count_ff  <= found ? cnt_next : '0;
         out_last_ff   <= 1'b1;
      end else if (cmd.scan_emit && sts.scan_match) begin
         out_status_ff <= rsd_pkg::STATUS_BUSIEST;
         out_server_ff <= rsd_pkg::SERVER_W'(scan_ff);
         out_count_ff  <= top_ff;
         out_last_ff   <= (scan_ff == lastidx_ff);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = rsd_pkg::RSP_DATA_W'({out_count_ff, out_server_ff});

endmodule

// ----- rtl/rotating_server_dispatcher.sv -----
// top level of the rotating server dispatcher
//
// channel   | direction | tdata (low bit up)                  | tuser          | tlast
// req_      | in        | arrival_time[29:0], load_time[59:30] | opcode         | -
// rsp_      | out       | server[3:0], handled_count[35:4]     | status         | last
// csr_      | in        | num_servers, written when csr_wr_en is high
//
// a dispatch request holds the input through the accepting state, a state that registers
// the free compare over all servers, and a state for the rotating pick and table update
// a report request holds the input through the accepting state, then a max scan
// and an emit scan over the count table, one server per cycle; emits stall while full
// one request is in flight at a time; reset is synchronous and clears all tables
module rotating_server_dispatcher #(
   parameter int MAX_SERVERS = rsd_pkg::MAX_SERVERS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rsd_pkg::NUM_W-1:0]      csr_wr_data,   // num_servers
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rsd_pkg::REQ_DATA_W-1:0] req_tdata,     // arrival_time, load_time
   input  logic [rsd_pkg::OPCODE_W-1:0]   req_tuser,     // opcode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rsd_pkg::RSP_DATA_W-1:0] rsp_tdata,     // server, handled_count
   output logic [rsd_pkg::STATUS_W-1:0]   rsp_tuser,     // status
   output logic                           rsp_tlast
);

   rsd_pkg::cmd_type cmd;
   rsd_pkg::sts_type sts;

   rsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .sts        (sts),
      .cmd        (cmd)
   );

   rsd_datapath #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_arrive  (req_tdata[rsd_pkg::ARRIVE_W-1:0]),
      .req_load    (req_tdata[rsd_pkg::ARRIVE_W +: rsd_pkg::LOAD_W]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
